>>> design/mexp_pkg.sv
// Shared constants and types for the modular exponentiation block.
`default_nettype none
package mexp_pkg;

  localparam int FIELD_W   = 32;
  localparam int OPERAND_W = 32;
  localparam int CNT_W     = $clog2(OPERAND_W);
  localparam int SUM_W     = OPERAND_W + 3;

  typedef logic [OPERAND_W-1:0] operand_t;
  typedef logic [OPERAND_W:0]   modulus_t;

  typedef struct packed {
    logic     go;
    operand_t mplier;
    operand_t mcand;
  } mul_req_t;

  typedef struct packed {
    logic     done;
    operand_t prod;
  } mul_rsp_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_NEXT   = 5'b00100,
    ST_MULT   = 5'b01000,
    ST_SQUARE = 5'b10000
  } state_t;

endpackage
`default_nettype wire

>>> design/modular_exponentiation.sv
// Top level: right-to-left square-and-multiply around a shared bit-serial multiplier.
// Sequence: each item needs one base reduction plus one square per exponent bit below
//   the highest set bit and one multiply per set bit, all through the shared multiplier.
// Throughput: one item at a time; busy stays high until the result strobe.
// Reset: synchronous active-low rst_n returns to idle and sets the modulus to 1.
// The result is shown for one cycle on out_valid; the receiver cannot stall it.
`default_nettype none
module modular_exponentiation (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  in_base_value,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  in_exponent_value,
  output logic                               out_valid,
  output logic [mexp_pkg::FIELD_W-1:0]       out_power_result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [mexp_pkg::FIELD_W-1:0]  cfg_modulus
);
  import mexp_pkg::*;

  state_t               state_r, state_nxt;
  operand_t             exp_r, exp_nxt;
  operand_t             base_r, base_nxt;
  operand_t             acc_r, acc_nxt;
  logic [FIELD_W-1:0]   modulus_r, modulus_nxt;
  logic [FIELD_W-1:0]   result_r, result_nxt;
  logic                 out_valid_r, out_valid_nxt;

  modulus_t             mod_ext;
  mul_req_t             mul_req;
  mul_rsp_t             mul_rsp;

  // A zero modulus means wrap at the operand width: treat it as 2^OPERAND_W
  always_comb begin
    if (modulus_r[OPERAND_W-1:0] == '0) begin
      mod_ext = {1'b1, {OPERAND_W{1'b0}}};
    end else begin
      mod_ext = {1'b0, modulus_r[OPERAND_W-1:0]};
    end
  end

  mexp_mulmod u_mulmod (
    .clk     (clk),
    .rst_n   (rst_n),
    .modulus (mod_ext),
    .req     (mul_req),
    .rsp     (mul_rsp)
  );

  always_comb begin
    state_nxt      = state_r;
    exp_nxt        = exp_r;
    base_nxt       = base_r;
    acc_nxt        = acc_r;
    result_nxt     = result_r;
    out_valid_nxt  = 1'b0;
    modulus_nxt    = modulus_r;
    mul_req.go     = 1'b0;
    mul_req.mplier = base_r;
    mul_req.mcand  = base_r;

    // Take configuration writes at any time; the user must send them only while idle (not enforced)
    if (cfg_valid) begin
      modulus_nxt = cfg_modulus;
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          // Reduce the base first: base * 1 mod m through the shared unit
          exp_nxt        = in_exponent_value[OPERAND_W-1:0];
          acc_nxt        = OPERAND_W'(1);
          mul_req.go     = 1'b1;
          mul_req.mplier = in_base_value[OPERAND_W-1:0];
          mul_req.mcand  = OPERAND_W'(1);
          state_nxt      = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mul_rsp.done) begin
          base_nxt  = mul_rsp.prod;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (exp_r == '0) begin
          // No bits left: deliver the running result, even the unreduced 1
          result_nxt    = FIELD_W'(acc_r);
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (exp_r[0]) begin
          mul_req.go     = 1'b1;
          mul_req.mplier = acc_r;
          mul_req.mcand  = base_r;
          state_nxt      = ST_MULT;
        end else begin
          mul_req.go = 1'b1;
          state_nxt  = ST_SQUARE;
        end
      end
      ST_MULT: begin
        if (mul_rsp.done) begin
          // Drop the bit just used so the next pass squares the base
          acc_nxt    = mul_rsp.prod;
          exp_nxt    = {exp_r[OPERAND_W-1:1], 1'b0};
          state_nxt  = ST_NEXT;
        end
      end
      ST_SQUARE: begin
        if (mul_rsp.done) begin
          base_nxt  = mul_rsp.prod;
          exp_nxt   = {1'b0, exp_r[OPERAND_W-1:1]};
          state_nxt = ST_NEXT;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      modulus_r   <= FIELD_W'(1);
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      modulus_r   <= modulus_nxt;
    end
    exp_r    <= exp_nxt;
    base_r   <= base_nxt;
    acc_r    <= acc_nxt;
    result_r <= result_nxt;
  end

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_power_result = result_r;

endmodule
`default_nettype wire

>>> design/mexp_mulmod.sv
// Bit-serial interleaved modular multiplier, one multiplier bit per cycle.
`default_nettype none
module mexp_mulmod (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire mexp_pkg::modulus_t modulus,
  input  wire mexp_pkg::mul_req_t req,
  output mexp_pkg::mul_rsp_t     rsp
);
  import mexp_pkg::*;

  operand_t          a_r, a_nxt;
  operand_t          b_r, b_nxt;
  operand_t          r_r, r_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              run_r, run_nxt;
  logic              done_r, done_nxt;

  logic [SUM_W-1:0]  sum;
  logic [SUM_W-1:0]  sub_one;
  logic [SUM_W-1:0]  sub_two;
  operand_t          step_val;

  // sum = 2r + bit*b stays below 3m; take off 0, m or 2m
  always_comb begin
    sum     = {2'b00, r_r, 1'b0} + (a_r[OPERAND_W-1] ? {3'b000, b_r} : '0);
    sub_one = sum - {2'b00, modulus};
    sub_two = sum - {1'b0, modulus, 1'b0};
    if (!sub_two[SUM_W-1]) begin
      step_val = sub_two[OPERAND_W-1:0];
    end else if (!sub_one[SUM_W-1]) begin
      step_val = sub_one[OPERAND_W-1:0];
    end else begin
      step_val = sum[OPERAND_W-1:0];
    end
  end

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    r_nxt    = r_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (req.go) begin
      a_nxt   = req.mplier;
      b_nxt   = req.mcand;
      r_nxt   = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      r_nxt   = step_val;
      a_nxt   = {a_r[OPERAND_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(OPERAND_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    r_r <= r_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.prod = r_r;

endmodule
`default_nettype wire
